[hw/rtl/rffvg_pkg.sv]
// ============================================================================
// rffvg_pkg: shared types and constants
// Types, constants and tables for the radial fill fan vertex generator.
// ============================================================================
package rffvg_pkg;

	localparam int MaxVerticesDef      = 11;
	localparam int AngleFracBitsDef    = 6;
	localparam int CordicIterationsDef = 16;
	localparam int AtanLen             = 24;

	localparam logic [14:0] StartAngleRst   = 15'd5760;
	localparam logic [16:0] SweepFractionRst = 17'd19661;
	localparam logic        ReverseRst      = 1'b1;

	localparam logic [31:0] CordicGainQ30 = 32'd652032875;

	localparam logic [1:0] REG_START_ANGLE = 2'd0;
	localparam logic [1:0] REG_SWEEP       = 2'd1;
	localparam logic [1:0] REG_REVERSE     = 2'd2;

	typedef struct packed {
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] tex_left;
		logic [15:0] tex_right;
		logic [15:0] tex_top;
		logic [15:0] tex_bottom;
	} req_t;

	typedef struct packed {
		logic [3:0]         vertex_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic               last_vertex;
	} vtx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_CENTER,
		ST_CORDIC,
		ST_SCALE,
		ST_DIVU,
		ST_TEXU,
		ST_TEXV,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, init sqrt
		logic sqrt_step;
		logic center;    // build center vertex
		logic cor_init;
		logic cor_step;
		logic scale;     // multiply and clamp
		logic div_init_u;
		logic div_init_v;
		logic div_step;
		logic emit;      // load output register
		logic advance;   // step angle
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sqrt_done;
		logic cor_done;
		logic div_done;
		logic is_last;
	} sts_t;

	function automatic logic [31:0] atan_q20(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd47185920;
				5'd1: r = 32'd27855475;
				5'd2: r = 32'd14718068;
				5'd3: r = 32'd7471121;
				5'd4: r = 32'd3750058;
				5'd5: r = 32'd1876857;
				5'd6: r = 32'd938658;
				5'd7: r = 32'd469357;
				5'd8: r = 32'd234682;
				5'd9: r = 32'd117342;
				5'd10: r = 32'd58671;
				5'd11: r = 32'd29335;
				5'd12: r = 32'd14668;
				5'd13: r = 32'd7334;
				5'd14: r = 32'd3667;
				5'd15: r = 32'd1833;
				5'd16: r = 32'd917;
				5'd17: r = 32'd458;
				5'd18: r = 32'd229;
				5'd19: r = 32'd115;
				5'd20: r = 32'd57;
				5'd21: r = 32'd29;
				5'd22: r = 32'd14;
				5'd23: r = 32'd7;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

[hw/rtl/rffvg_ctrl.sv]
// ============================================================================
// rffvg_ctrl: sequencer
// Steps through sqrt once, then cordic, scaling and divides per rim vertex.
// ============================================================================
module rffvg_ctrl import rffvg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_busy,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_done) begin
					state_d = ST_CENTER;
				end
			end
			ST_CENTER: begin
				cmd.center     = 1'b1;
				cmd.div_init_u = 1'b1;
				state_d        = ST_TEXU;
			end
			ST_CORDIC: begin
				cmd.cor_step = 1'b1;
				if (sts.cor_done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale      = 1'b1;
				state_d        = ST_DIVU;
			end
			// u divide starts once the scaled position is registered
			ST_DIVU: begin
				cmd.div_init_u = 1'b1;
				state_d        = ST_TEXU;
			end
			ST_TEXU: begin
				if (sts.div_done) begin
					cmd.div_init_v = 1'b1;
					state_d        = ST_TEXV;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_TEXV: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!out_busy) begin
					cmd.emit = 1'b1;
					if (sts.is_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			ST_WAIT: begin
				cmd.advance  = 1'b1;
				cmd.cor_init = 1'b1;
				state_d      = ST_CORDIC;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hw/rtl/rffvg_datapath.sv]
// ============================================================================
// rffvg_datapath: arithmetic units
// Integer sqrt, rotation CORDIC, scale/clamp, restoring divider, angle walk.
// ============================================================================
module rffvg_datapath import rffvg_pkg::*; #(
	parameter int MAX_VERTICES      = MaxVerticesDef,
	parameter int ANGLE_FRAC_BITS   = AngleFracBitsDef,
	parameter int CORDIC_ITERATIONS = CordicIterationsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  req_t        req,
	input  logic [14:0] start_angle,
	input  logic [16:0] sweep_fraction,
	input  logic        reverse,
	output vtx_t        vtx
);

	localparam int AW        = 9 + ANGLE_FRAC_BITS + 1;
	localparam int FullTurn  = 360 << ANGLE_FRAC_BITS;
	localparam int HalfTurn  = 180 << ANGLE_FRAC_BITS;
	localparam int QtrTurn   = 90 << ANGLE_FRAC_BITS;
	localparam int Step45    = 45 << ANGLE_FRAC_BITS;
	localparam int ZShift    = 20 - ANGLE_FRAC_BITS;
	localparam int NIter     = (CORDIC_ITERATIONS < AtanLen) ? CORDIC_ITERATIONS : AtanLen;
	localparam int VCW       = $clog2(MAX_VERTICES + 1);
	// conditional subtracts needed to bring a 15-bit angle below a full turn
	localparam int ModSteps  = (FullTurn > 32767) ? 1 : $clog2(32768 / FullTurn) + 1;

	// request
	logic [14:0] hw_q, hh_q;
	logic [15:0] tl_q, tt_q;
	logic signed [16:0] tw_q, th_q;

	// sqrt (restoring, 2 bits per step)
	logic [31:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [31:0] sq_t;
	assign sq_t = sq_res_q + sq_bit_q;

	// angle walk
	logic [AW-1:0] angle_q, ax_q, dv_q;
	logic          quit_q;
	logic          quit2_q;
	logic [VCW-1:0] n_q;

	// cordic
	logic signed [33:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic               neg_q;
	logic [4:0]         ci_q;

	// scaled position
	logic signed [16:0] px_q, py_q;

	// divider: q = (mag*num + den/2) / den
	logic [33:0] dn_q;
	logic [16:0] dd_q;
	logic [33:0] dq_q;
	logic [17:0] drem_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q;
	logic [15:0] tu_q;

	// ---- angle preprocessing
	logic [AW-1:0] start_mod;
	logic [16:0]   sw_sat;
	logic [AW+16:0] ax_prod;
	logic [31:0]   sm_w;
	always_comb begin
		sm_w = 32'(start_angle);
		for (int k = ModSteps - 1; k >= 0; k--) begin
			if (sm_w >= 32'(FullTurn << k)) sm_w = sm_w - 32'(FullTurn << k);
		end
		start_mod = AW'(sm_w);
		sw_sat    = (sweep_fraction > 17'd65536) ? 17'd65536 : sweep_fraction;
		ax_prod   = (AW+17)'(sw_sat) * (AW+17)'(FullTurn);
	end

	// ---- cordic angle fold
	logic signed [AW+1:0] as_w;
	logic                 neg_w;
	always_comb begin
		as_w  = (AW+2)'($signed({2'b0, angle_q}));
		neg_w = 1'b0;
		if (as_w > HalfTurn) as_w = as_w - (AW+2)'(FullTurn);
		if (as_w > QtrTurn) begin
			as_w  = as_w - (AW+2)'(HalfTurn);
			neg_w = 1'b1;
		end else if (as_w < -QtrTurn) begin
			as_w  = as_w + (AW+2)'(HalfTurn);
			neg_w = 1'b1;
		end
	end

	// cordic outputs with the quadrant fold undone, before rounding
	logic signed [33:0] cxs, cys;
	always_comb begin
		cxs = neg_q ? -cx_q : cx_q;
		cys = neg_q ? -cy_q : cy_q;
	end

	// ---- scale products
	logic signed [51:0] mx, my;
	logic signed [21:0] rx, ry;
	logic signed [16:0] hwx, hhy;
	always_comb begin
		mx  = 52'(cxs) * 52'($signed({1'b0, sq_res_q[16:0]})) + 52'sd536870912;
		my  = 52'(cys) * 52'($signed({1'b0, sq_res_q[16:0]})) + 52'sd536870912;
		rx  = 22'(mx >>> 30);
		ry  = 22'(my >>> 30);
		hwx = $signed({2'b0, hw_q});
		hhy = $signed({2'b0, hh_q});
	end

	logic signed [16:0] cx_c, cy_c;
	always_comb begin
		if (rx > 22'(hwx)) cx_c = hwx;
		else if (rx < -22'(hwx)) cx_c = -hwx;
		else cx_c = 17'(rx);
		if (ry > 22'(hhy)) cy_c = hhy;
		else if (ry < -22'(hhy)) cy_c = -hhy;
		else cy_c = 17'(ry);
	end

	// ---- divider setup
	logic signed [16:0] span_w;
	logic [15:0]        base_w;
	logic [16:0]        mag_w, num_w, den_w;
	logic               zero_w, spneg_w;
	always_comb begin
		if (cmd.div_init_u) begin
			span_w = tw_q;
			zero_w = (hw_q == '0);
			num_w  = 17'($signed({2'b0, hw_q}) + px_q);
			den_w  = {1'b0, hw_q, 1'b0};
		end else begin
			span_w = th_q;
			zero_w = (hh_q == '0);
			num_w  = 17'($signed({2'b0, hh_q}) - py_q);
			den_w  = {1'b0, hh_q, 1'b0};
		end
		if (zero_w) begin
			num_w = 17'd1;
			den_w = 17'd2;
		end
		spneg_w = span_w[16];
		mag_w   = spneg_w ? 17'(-span_w) : 17'(span_w);
		base_w  = cmd.div_init_u ? tl_q : tt_q;
	end

	logic [17:0] drem_sh;
	assign drem_sh = {drem_q[16:0], dn_q[33]};

	logic [15:0] div_res;
	assign div_res = dneg_q ? 16'(tu_q - dq_q[15:0]) : 16'(tu_q + dq_q[15:0]);

	logic [AW-1:0] dv_use;
	logic          quit_n;
	always_comb begin
		quit_n = quit_q;
		dv_use = dv_q;
		if (ax_q < dv_q) begin
			dv_use = ax_q;
			quit_n = 1'b1;
		end
	end

	logic [15:0] tex_u_q;

	// the angle walk runs one vertex ahead of the emitted vertex, so a stop
	// decided at one advance flags the vertex two emits later
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			quit_q  <= 1'b0;
			quit2_q <= 1'b0;
			ci_q    <= '0;
			dcnt_q  <= '0;
		end else begin
			if (cmd.load) begin
				n_q     <= '0;
				quit_q  <= 1'b0;
				quit2_q <= 1'b0;
			end
			if (cmd.emit) n_q <= n_q + 1'b1;
			if (cmd.advance) begin
				quit_q  <= quit_n;
				quit2_q <= quit_q;
			end
			if (cmd.cor_init) ci_q <= '0;
			else if (cmd.cor_step) ci_q <= ci_q + 1'b1;
			if (cmd.div_init_u || cmd.div_init_v) dcnt_q <= 6'd0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hw_q     <= req.width[15:1];
			hh_q     <= req.height[15:1];
			tl_q     <= req.tex_left;
			tt_q     <= req.tex_top;
			tw_q     <= $signed({1'b0, req.tex_right}) - $signed({1'b0, req.tex_left});
			th_q     <= $signed({1'b0, req.tex_bottom}) - $signed({1'b0, req.tex_top});
			sq_v_q   <= 32'({15'd0, req.width[15:1]}) * 32'({15'd0, req.width[15:1]})
				+ 32'({15'd0, req.height[15:1]}) * 32'({15'd0, req.height[15:1]});
			sq_res_q <= '0;
			sq_bit_q <= 32'h4000_0000;
			angle_q  <= start_mod;
			ax_q     <= AW'(ax_prod >> 16);
			if (start_mod < AW'(Step45))
				dv_q <= reverse ? start_mod : AW'(Step45) - start_mod;
			else
				dv_q <= AW'(Step45);
			px_q     <= '0;
			py_q     <= '0;
		end
		if (cmd.sqrt_step && sq_bit_q != '0) begin
			if (sq_v_q >= sq_t) begin
				sq_v_q   <= sq_v_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.center) begin
			px_q <= '0;
			py_q <= '0;
		end
		if (cmd.advance) begin
			if (reverse)
				angle_q <= (angle_q >= dv_use) ? angle_q - dv_use
					: AW'(angle_q + AW'(FullTurn) - dv_use);
			else
				angle_q <= (AW'(angle_q + dv_use) >= AW'(FullTurn))
					? AW'(angle_q + dv_use - AW'(FullTurn)) : AW'(angle_q + dv_use);
			ax_q <= ax_q - dv_use;
			dv_q <= AW'(Step45);
		end
		if (cmd.cor_init) begin
			cx_q  <= 34'($signed({2'b0, CordicGainQ30}));
			cy_q  <= '0;
			cz_q  <= 32'(as_w) <<< ZShift;
			neg_q <= neg_w;
		end
		if (cmd.cor_step) begin
			if (!cz_q[31]) begin
				cx_q <= cx_q - (cy_q >>> ci_q);
				cy_q <= cy_q + (cx_q >>> ci_q);
				cz_q <= cz_q - $signed(atan_q20(ci_q));
			end else begin
				cx_q <= cx_q + (cy_q >>> ci_q);
				cy_q <= cy_q - (cx_q >>> ci_q);
				cz_q <= cz_q + $signed(atan_q20(ci_q));
			end
		end
		if (cmd.scale) begin
			px_q <= cx_c;
			py_q <= cy_c;
		end
		if (cmd.div_init_u || cmd.div_init_v) begin
			dn_q   <= 34'(mag_w) * 34'(num_w) + 34'(den_w >> 1);
			dd_q   <= den_w;
			dq_q   <= '0;
			drem_q <= '0;
			dneg_q <= spneg_w;
			tu_q   <= base_w;
		end
		if (cmd.div_step) begin
			dn_q <= dn_q << 1;
			if (drem_sh >= {1'b0, dd_q}) begin
				drem_q <= drem_sh - {1'b0, dd_q};
				dq_q   <= {dq_q[32:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				dq_q   <= {dq_q[32:0], 1'b0};
			end
		end
		if (cmd.div_init_v) tex_u_q <= div_res;
	end

	logic signed [16:0] sx_c, sy_c;
	assign sx_c = px_q;
	assign sy_c = py_q;

	always_comb begin
		sts.sqrt_done = (sq_bit_q == '0);
		sts.cor_done  = (ci_q == 5'(NIter - 1));
		sts.div_done  = (dcnt_q == 6'd34);
		sts.is_last   = quit2_q || (32'(n_q) == 32'(MAX_VERTICES - 1));
	end

	always_comb begin
		vtx.vertex_index = 4'(n_q);
		vtx.pos_x        = sx_c[15:0];
		vtx.pos_y        = sy_c[15:0];
		vtx.tex_u        = tex_u_q;
		vtx.tex_v        = div_res;
		vtx.last_vertex  = sts.is_last;
	end

endmodule

[hw/rtl/radial_fill_fan_vertex_generator_core.sv]
// ============================================================================
// radial_fill_fan_vertex_generator_core: top level
// Triangle fan generator for radial progress fills.
// ============================================================================
// Usage:
//   in_* channel takes one transaction (sprite size + texture rectangle).
//   out_* channel returns one transaction per fan vertex, 3..MAX_VERTICES,
//   the final one with last_vertex set.
//   Config: cfg_we/cfg_index/cfg_data write start_angle, sweep_fraction and
//   reverse; write only while idle.
// Sequence: the integer sqrt runs once per request; each rim vertex then
//   takes a CORDIC rotation, scaling, and restoring divides for u and then
//   v before it is emitted. The center vertex skips CORDIC and scaling.
// Throughput: one request at a time; in_ready is high only when idle.
// Reset: clears controller, output valid and config to defaults.
// Stall: the output register holds a vertex until taken; the sequencer
//   waits before loading the next one.
// ============================================================================
module radial_fill_fan_vertex_generator_core import rffvg_pkg::*; #(
	parameter int MAX_VERTICES      = MaxVerticesDef,
	parameter int ANGLE_FRAC_BITS   = AngleFracBitsDef,
	parameter int CORDIC_ITERATIONS = CordicIterationsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output vtx_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	logic [14:0] start_angle_q;
	logic [16:0] sweep_q;
	logic        reverse_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= StartAngleRst;
			sweep_q       <= SweepFractionRst;
			reverse_q     <= ReverseRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ANGLE: start_angle_q <= cfg_data[14:0];
				REG_SWEEP:       sweep_q       <= cfg_data;
				REG_REVERSE:     reverse_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cmd_t cmd;
	sts_t sts;
	vtx_t vtx;
	logic out_busy;

	// busy when output full and not being drained this cycle
	assign out_busy = out_valid && !out_ready;

	rffvg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_busy (out_busy),
		.sts      (sts),
		.cmd      (cmd)
	);

	rffvg_datapath #(
		.MAX_VERTICES      (MAX_VERTICES),
		.ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS),
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req            (in_data),
		.start_angle    (start_angle_q),
		.sweep_fraction (sweep_q),
		.reverse        (reverse_q),
		.vtx            (vtx)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_data <= vtx;
	end

endmodule

[hw/rtl/rffvg_checker.sv]
// ============================================================================
// rffvg_checker: port-level checks
// Watches the top level's channels over time.
// ============================================================================
module rffvg_checker import rffvg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input vtx_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	a_busy_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_vertex |-> !in_ready)
		else $error("input taken mid fan");

	a_idx_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || out_data.last_vertex)
		else $error("accept before fan done");

endmodule

bind radial_fill_fan_vertex_generator_core rffvg_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for radial_fill_fan_vertex_generator_core
// Drives sprite requests and config writes, predicts every fan vertex with
// an independent fixed-point model, and checks each vertex transaction.
// ----------------------------------------------------------------------------
module tb;
	import rffvg_pkg::*;

	localparam int FULL_TURN = 23040;  // 360 deg in 1/64 deg
	localparam int STEP_45   = 2880;

	// Predictor of the fan plus the queue of vertices still owed by the block.
	class fan_scoreboard;
		int unsigned start_angle = StartAngleRst;
		int unsigned sweep_frac  = SweepFractionRst;
		bit          reverse     = ReverseRst;
		vtx_t        fan_vertex_q[$];
		int          mismatches;
		int          requests;
		int          vertices;
		longint      atan_tab[16] = '{47185920, 27855475, 14718068, 7471121,
			3750058, 1876857, 938658, 469357, 234682, 117342, 58671, 29335,
			14668, 7334, 3667, 1833};

		function longint root_floor(longint unsigned v);
			longint unsigned res, bit_pos;
			res = 0;
			bit_pos = 64'd1 << 62;
			while (bit_pos > v) bit_pos >>= 2;
			while (bit_pos != 0) begin
				if (v >= res + bit_pos) begin
					v -= res + bit_pos;
					res = (res >> 1) + bit_pos;
				end else begin
					res >>= 1;
				end
				bit_pos >>= 2;
			end
			return longint'(res);
		endfunction

		// cos/sin in Q2.30, rotation-mode CORDIC on 2^-20 degree residual
		function void rotate(input longint a, output longint c, output longint s);
			longint ang, x, y, z, dx, dy;
			bit flip;
			ang = a;
			flip = 0;
			x = 652032875;
			y = 0;
			if (ang > FULL_TURN / 2) ang -= FULL_TURN;
			if (ang > FULL_TURN / 4) begin
				ang -= FULL_TURN / 2;
				flip = 1;
			end else if (ang < -FULL_TURN / 4) begin
				ang += FULL_TURN / 2;
				flip = 1;
			end
			z = ang * 16384;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_tab[i];
				end else begin
					x += dx; y -= dy; z += atan_tab[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint clamp_sym(longint v, longint lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		// base + rounded(span * num / den), sign of span kept
		function logic [15:0] tex_lerp(longint base, longint span, longint num,
			longint den);
			longint mag, q;
			mag = span < 0 ? -span : span;
			q = (mag * num + den / 2) / den;
			return 16'(span < 0 ? base - q : base + q);
		endfunction

		function vtx_t make_vertex(int idx, longint x, longint y, longint hw,
			longint hh, req_t r);
			vtx_t v;
			longint tu_span, tv_span;
			tu_span = longint'(r.tex_right) - longint'(r.tex_left);
			tv_span = longint'(r.tex_bottom) - longint'(r.tex_top);
			v.vertex_index = 4'(idx);
			v.pos_x = 16'(x);
			v.pos_y = 16'(y);
			v.tex_u = hw == 0 ? tex_lerp(r.tex_left, tu_span, 1, 2)
				: tex_lerp(r.tex_left, tu_span, hw + x, 2 * hw);
			v.tex_v = hh == 0 ? tex_lerp(r.tex_top, tv_span, 1, 2)
				: tex_lerp(r.tex_top, tv_span, hh - y, 2 * hh);
			v.last_vertex = 1'b0;
			return v;
		endfunction

		function void note_request(req_t r);
			vtx_t fan[$];
			longint hw, hh, rad, ang, rem, step, c, s, x, y;
			bit quit;
			hw = r.width >> 1;
			hh = r.height >> 1;
			rad = root_floor(hw * hw + hh * hh);
			rem = ((sweep_frac > 65536 ? 65536 : sweep_frac) * longint'(FULL_TURN)) >> 16;
			ang = start_angle % FULL_TURN;
			quit = 0;
			fan.push_back(make_vertex(0, 0, 0, hw, hh, r));
			if (ang < STEP_45) step = reverse ? ang : STEP_45 - ang;
			else step = STEP_45;
			for (int i = 1; i < 11; i++) begin
				rotate(ang, c, s);
				x = clamp_sym((c * rad + (64'sd1 << 29)) >>> 30, hw);
				y = clamp_sym((s * rad + (64'sd1 << 29)) >>> 30, hh);
				fan.push_back(make_vertex(i, x, y, hw, hh, r));
				if (quit) break;
				// remaining sweep short of the step: one more vertex, then stop
				if (rem < step) begin
					step = rem;
					quit = 1;
				end
				ang = reverse ? (ang + FULL_TURN - step) % FULL_TURN
					: (ang + step) % FULL_TURN;
				rem -= step;
				step = STEP_45;
			end
			fan[fan.size() - 1].last_vertex = 1'b1;
			foreach (fan[i]) fan_vertex_q.push_back(fan[i]);
			requests++;
		endfunction

		function void check_vertex(vtx_t got);
			vtx_t want;
			vertices++;
			if (fan_vertex_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected vertex transaction: %p", got);
				return;
			end
			want = fan_vertex_q.pop_front();
			if (got.vertex_index !== want.vertex_index || got.pos_x !== want.pos_x ||
				got.pos_y !== want.pos_y || got.tex_u !== want.tex_u ||
				got.tex_v !== want.tex_v || got.last_vertex !== want.last_vertex) begin
				mismatches++;
				if (mismatches <= 10)
					$display("vertex mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	req_t        in_data = '0;
	logic        out_valid;
	logic        out_ready = 0;
	vtx_t        out_data;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_START_ANGLE;
	logic [16:0] cfg_data = '0;

	fan_scoreboard sb = new();
	bit send_gaps = 1;    // random idle bursts on the request side
	bit recv_gaps = 1;    // random stall bursts on the vertex side
	bit squeeze_go = 0;   // kicks off the long receiver hold-off
	bit squeeze_on = 0;
	int stall_left = 0;
	int phases = 0;

	radial_fill_fan_vertex_generator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// monitors: sample at the rising edge, before the block's own updates land
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_request(in_data);
		if (arst_n && out_valid && out_ready) sb.check_vertex(out_data);
	end

	// vertex receiver: short random stalls, or the long hold-off when asked
	always @(negedge clk) begin
		if (squeeze_on) begin
			out_ready = 0;
		end else if (stall_left > 0) begin
			out_ready = 0;
			stall_left--;
		end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
			out_ready = 0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready = 1;
		end
	end

	// long hold-off, counted here so the sender keeps offering meanwhile
	initial begin
		wait (squeeze_go);
		squeeze_on = 1;
		repeat (400) @(negedge clk);
		squeeze_on = 0;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// hold valid until the transaction goes through; valid left high after
	task automatic send_request(req_t r);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1;
		in_data = r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 0;
		while (sb.fan_vertex_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			REG_START_ANGLE: sb.start_angle = val[14:0];
			REG_SWEEP:       sb.sweep_frac = val;
			default:         sb.reverse = val[0];
		endcase
	endtask

	task automatic set_fan(logic [16:0] start, logic [16:0] sweep, logic rev);
		drain();
		write_reg(REG_START_ANGLE, start);
		write_reg(REG_SWEEP, sweep);
		write_reg(REG_REVERSE, {16'd0, rev});
		phases++;
	endtask

	function automatic req_t make_request(logic [15:0] w, logic [15:0] h,
		logic [15:0] tl, logic [15:0] tr, logic [15:0] tt, logic [15:0] tb_);
		req_t r;
		r.width = w; r.height = h;
		r.tex_left = tl; r.tex_right = tr; r.tex_top = tt; r.tex_bottom = tb_;
		return r;
	endfunction

	// mostly modest sprites, sometimes any size up to the field limit
	function automatic req_t random_request();
		logic [15:0] w, h;
		w = $urandom_range(0, 2) == 0 ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 2048));
		h = $urandom_range(0, 2) == 0 ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 2048));
		return make_request(w, h, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endfunction

	initial begin
		logic [16:0] sweep;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset settings: zero extents, full extents, reversed texture spans
		send_request(make_request(16'd1, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
		send_request(make_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0));
		send_request(make_request(16'd2, 16'hFFFF, 16'h1234, 16'h1234, 16'hAAAA, 16'h5555));
		send_request(make_request(16'hFFFF, 16'd3, 16'h5555, 16'hAAAA, 16'd1, 16'hFFFE));

		// whole circle upward from zero: runs into the vertex limit
		set_fan(17'd0, 17'd65536, 1'b0);
		send_request(make_request(16'd640, 16'd320, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
		send_request(make_request(16'd1, 16'd4000, 16'd100, 16'd900, 16'd900, 16'd100));

		// zero start going downward: first step collapses to zero
		set_fan(17'd0, 17'd30000, 1'b1);
		send_request(make_request(16'd800, 16'd800, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF));

		// start under 45 deg: first step is the rest of the way to 45 deg
		// going up, or the start angle itself going down
		set_fan(17'd1000, 17'd8192, 1'b0);
		send_request(make_request(16'd500, 16'd700, 16'd0, 16'h8000, 16'h8000, 16'hFFFF));
		set_fan(17'd1000, 17'd8192, 1'b1);
		send_request(make_request(16'd700, 16'd500, 16'd0, 16'h8000, 16'h8000, 16'hFFFF));

		// start past a full turn wraps; oversized sweep saturates
		set_fan(17'd32767, 17'd131071, 1'b1);
		send_request(make_request(16'd1000, 16'd1000, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
		send_request(make_request(16'hFFFF, 16'hFFFF, 16'd7, 16'd3, 16'd9, 16'd2));

		// last legal angle, empty sweep: center plus two rim vertices at the
		// same angle
		set_fan(17'd23039, 17'd0, 1'b0);
		send_request(make_request(16'd333, 16'd999, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF));

		// random phases; the long receiver hold-off lands in the third
		for (int p = 0; p < 7; p++) begin
			case ($urandom_range(0, 3))
				0: sweep = 17'($urandom_range(0, 131071));
				1: sweep = 17'($urandom_range(0, 8192));
				default: sweep = 17'($urandom_range(20000, 65536));
			endcase
			set_fan(17'($urandom_range(0, 32767)), sweep, 1'($urandom));
			if (p == 2) squeeze_go = 1;
			if (p == 6) begin
				send_gaps = 0;
				recv_gaps = 0;
			end
			repeat (14) send_request(random_request());
		end
		drain();

		$display("covered %0d requests and %0d vertices over %0d register settings",
			sb.requests, sb.vertices, phases);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.fan_vertex_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
